// ===== sv/rss_pkg.sv =====
// Shared types and constants of the rotated sprite sampler.
package rss_pkg;

  localparam int MaxWidth   = 64;
  localparam int MaxHeight  = 64;
  localparam int CoordBits  = 12;
  localparam int ColBits    = $clog2(MaxWidth);
  localparam int RowBits    = $clog2(MaxHeight);
  localparam int StoreDepth = MaxWidth * MaxHeight;
  localparam int AddrBits   = ColBits + RowBits;
  localparam int CellBits   = 24;

  localparam int HalfQ14    = 8192;
  localparam int HalfQ28    = 1 << 27;

  // Box terms: 7-bit size times Q2.14, sums of two such products
  localparam int ProdBits   = 24;
  localparam int DimBits    = 25;
  localparam int PosBits    = 15;

  // Cycles from a register write until the derived box is current
  localparam int SettleCycles = 3;

  typedef enum logic [2:0] {
    REG_SINE        = 3'd0,
    REG_COSINE      = 3'd1,
    REG_WIDTH       = 3'd2,
    REG_HEIGHT      = 3'd3,
    REG_POS_X       = 3'd4,
    REG_POS_Y       = 3'd5,
    REG_TRANSPARENT = 3'd6
  } cfg_reg_e;

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_SAMPLE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    WM_NONE = 2'd0,
    WM_FULL = 2'd1,
    WM_CHAR = 2'd2
  } wmode_e;

  typedef struct packed {
    logic                        opcode;
    logic [5:0]                  cell_column;
    logic [5:0]                  cell_row;
    logic [7:0]                  cell_char;
    logic [15:0]                 cell_color;
    logic signed [CoordBits-1:0] screen_x;
    logic signed [CoordBits-1:0] screen_y;
  } in_t;

  typedef struct packed {
    logic       hit;
    logic [7:0] out_char;
    logic [15:0] out_color;
    logic [1:0] write_mode;
    logic [5:0] source_column;
    logic [5:0] source_row;
  } out_t;

  typedef struct packed {
    logic signed [15:0]          sine;
    logic signed [15:0]          cosine;
    logic [6:0]                  width;
    logic [6:0]                  height;
    logic signed [CoordBits-1:0] pos_x;
    logic signed [CoordBits-1:0] pos_y;
    logic [15:0]                 transparent;
  } cfg_t;

  typedef struct packed {
    logic signed [DimBits-1:0] min_x;
    logic signed [DimBits-1:0] min_y;
    logic signed [PosBits-1:0] left;
    logic signed [PosBits-1:0] top;
  } box_t;

  // Mapper result heading into the image store
  typedef struct packed {
    logic                valid;
    logic                opcode;
    logic                hit;
    logic [ColBits-1:0]  src_col;
    logic [RowBits-1:0]  src_row;
    logic [ColBits-1:0]  cell_col;
    logic [RowBits-1:0]  cell_row;
    logic [CellBits-1:0] cell_data;
  } map_t;

endpackage

// ===== sv/rss_geometry.sv =====
// Configuration registers and the pipelined rotated bounding box.
module rss_geometry (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  input  logic [2:0]       cfg_index_i,
  input  logic [15:0]      cfg_data_i,
  output rss_pkg::cfg_t    cfg_o,
  output rss_pkg::box_t    box_o,
  output logic             busy_o
);
  import rss_pkg::*;

  localparam cfg_t CfgReset = '{
    sine:        '0,
    cosine:      16'sd16384,
    width:       '0,
    height:      '0,
    pos_x:       '0,
    pos_y:       '0,
    transparent: '0
  };

  cfg_t cfg_q, cfg_d;
  logic [1:0] settle_q, settle_d;

  logic signed [ProdBits-1:0] hs_q, hc_q, ws_q, wc_q;
  logic signed [DimBits-1:0]  min_x_q, max_x_q, min_y_q, max_y_q;
  box_t box_q;

  logic [6:0] sat_w, sat_h;

  function automatic logic signed [DimBits-1:0] min4(
    input logic signed [DimBits-1:0] a, input logic signed [DimBits-1:0] b,
    input logic signed [DimBits-1:0] c, input logic signed [DimBits-1:0] d);
    logic signed [DimBits-1:0] m;
    m = a;
    if (b < m) m = b;
    if (c < m) m = c;
    if (d < m) m = d;
    return m;
  endfunction

  function automatic logic signed [DimBits-1:0] max4(
    input logic signed [DimBits-1:0] a, input logic signed [DimBits-1:0] b,
    input logic signed [DimBits-1:0] c, input logic signed [DimBits-1:0] d);
    logic signed [DimBits-1:0] m;
    m = a;
    if (b > m) m = b;
    if (c > m) m = c;
    if (d > m) m = d;
    return m;
  endfunction

  assign sat_w = (cfg_data_i[6:0] > 7'(MaxWidth))  ? 7'(MaxWidth)  : cfg_data_i[6:0];
  assign sat_h = (cfg_data_i[6:0] > 7'(MaxHeight)) ? 7'(MaxHeight) : cfg_data_i[6:0];

  always_comb begin
    cfg_d    = cfg_q;
    settle_d = (settle_q != 2'd0) ? settle_q - 2'd1 : 2'd0;
    if (cfg_valid_i) begin
      settle_d = 2'(SettleCycles);
      case (cfg_index_i)
        REG_SINE:        cfg_d.sine        = cfg_data_i;
        REG_COSINE:      cfg_d.cosine      = cfg_data_i;
        REG_WIDTH:       cfg_d.width       = sat_w;
        REG_HEIGHT:      cfg_d.height      = sat_h;
        REG_POS_X:       cfg_d.pos_x       = cfg_data_i[CoordBits-1:0];
        REG_POS_Y:       cfg_d.pos_y       = cfg_data_i[CoordBits-1:0];
        REG_TRANSPARENT: cfg_d.transparent = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q    <= CfgReset;
      settle_q <= 2'(SettleCycles);
    end else begin
      cfg_q    <= cfg_d;
      settle_q <= settle_d;
    end
  end

  // Stage A: corner products
  always_ff @(posedge clk_i) begin
    hs_q <= $signed({1'b0, cfg_q.height}) * cfg_q.sine;
    hc_q <= $signed({1'b0, cfg_q.height}) * cfg_q.cosine;
    ws_q <= $signed({1'b0, cfg_q.width})  * cfg_q.sine;
    wc_q <= $signed({1'b0, cfg_q.width})  * cfg_q.cosine;
  end

  // Stage B: extents over the three corners and the origin
  always_ff @(posedge clk_i) begin
    min_x_q <= min4(-DimBits'(hs_q), DimBits'(wc_q) - DimBits'(hs_q), DimBits'(wc_q), '0);
    max_x_q <= max4(-DimBits'(hs_q), DimBits'(wc_q) - DimBits'(hs_q), DimBits'(wc_q), '0);
    min_y_q <= min4(DimBits'(hc_q), DimBits'(hc_q) + DimBits'(ws_q), DimBits'(ws_q), '0);
    max_y_q <= max4(DimBits'(hc_q), DimBits'(hc_q) + DimBits'(ws_q), DimBits'(ws_q), '0);
  end

  // Stage C: rounded box size, box centred on the object
  logic signed [DimBits:0]    span_x, span_y;
  logic [11:0]                box_w, box_h;
  logic signed [PosBits-1:0]  half_w, half_h, half_bw, half_bh;

  always_comb begin
    span_x  = (DimBits+1)'(max_x_q) - (DimBits+1)'(min_x_q) + (DimBits+1)'(HalfQ14);
    span_y  = (DimBits+1)'(max_y_q) - (DimBits+1)'(min_y_q) + (DimBits+1)'(HalfQ14);
    box_w   = span_x[DimBits:14];
    box_h   = span_y[DimBits:14];
    half_w  = $signed({9'd0, cfg_q.width[6:1]});
    half_h  = $signed({9'd0, cfg_q.height[6:1]});
    half_bw = $signed({4'd0, box_w[11:1]});
    half_bh = $signed({4'd0, box_h[11:1]});
  end

  always_ff @(posedge clk_i) begin
    box_q.min_x <= min_x_q;
    box_q.min_y <= min_y_q;
    box_q.left  <= PosBits'(cfg_q.pos_x) + half_w - half_bw;
    box_q.top   <= PosBits'(cfg_q.pos_y) + half_h - half_bh;
  end

  assign cfg_o  = cfg_q;
  assign box_o  = box_q;
  assign busy_o = (settle_q != 2'd0);

endmodule

// ===== sv/rss_mapper.sv =====
// Three-stage inverse rotation of a screen coordinate into the image.
module rss_mapper (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          adv_i,
  input  logic          accept_i,
  input  rss_pkg::in_t  in_data_i,
  input  rss_pkg::cfg_t cfg_i,
  input  rss_pkg::box_t box_i,
  output rss_pkg::map_t map_o
);
  import rss_pkg::*;

  localparam int PBits = 32;
  localparam int MBits = PBits + 16;
  localparam int SBits = MBits + 2;

  logic s1_valid_q, s2_valid_q;
  in_t  s1_item_q, s2_item_q;
  logic signed [PBits-1:0] px_q, py_q;
  logic signed [MBits-1:0] xc_q, ys_q, yc_q, xs_q;
  map_t s3_q;

  logic signed [15:0] dx, dy;
  logic signed [SBits-1:0] sum_x, sum_y;
  logic signed [SBits-29:0] sx, sy;
  logic hit_x, hit_y;

  always_comb begin
    dx = 16'(in_data_i.screen_x) - 16'(box_i.left);
    dy = 16'(in_data_i.screen_y) - 16'(box_i.top);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
    end else if (adv_i) begin
      s1_valid_q  <= accept_i;
      s2_valid_q  <= s1_valid_q;
    end
  end

  // Stage 1: offset into the box, scaled to Q.14
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s1_item_q <= in_data_i;
      px_q <= PBits'($signed({dx, 14'd0})) + PBits'(box_i.min_x);
      py_q <= PBits'($signed({dy, 14'd0})) + PBits'(box_i.min_y);
    end
  end

  // Stage 2: rotation products, Q.28
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s2_item_q <= s1_item_q;
      xc_q <= px_q * cfg_i.cosine;
      ys_q <= py_q * cfg_i.sine;
      yc_q <= py_q * cfg_i.cosine;
      xs_q <= px_q * cfg_i.sine;
    end
  end

  // Stage 3: round to nearest, bounds check
  always_comb begin
    sum_x = SBits'(xc_q) + SBits'(ys_q) + SBits'(HalfQ28);
    sum_y = SBits'(yc_q) - SBits'(xs_q) + SBits'(HalfQ28);
    sx    = sum_x[SBits-1:28];
    sy    = sum_y[SBits-1:28];
    hit_x = !sx[SBits-29] && (sx[SBits-30:0] < (SBits-29)'(cfg_i.width));
    hit_y = !sy[SBits-29] && (sy[SBits-30:0] < (SBits-29)'(cfg_i.height));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_q <= '0;
    end else if (adv_i) begin
      s3_q.valid     <= s2_valid_q;
      s3_q.opcode    <= s2_item_q.opcode;
      s3_q.hit       <= hit_x && hit_y;
      s3_q.src_col   <= sx[ColBits-1:0];
      s3_q.src_row   <= sy[RowBits-1:0];
      s3_q.cell_col  <= s2_item_q.cell_column[ColBits-1:0];
      s3_q.cell_row  <= s2_item_q.cell_row[RowBits-1:0];
      s3_q.cell_data <= {s2_item_q.cell_color, s2_item_q.cell_char};
    end
  end

  assign map_o = s3_q;

endmodule

// ===== sv/rss_store.sv =====
// Image cell memory: one write port, one registered read port.
module rss_store (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic [rss_pkg::AddrBits-1:0] waddr_i,
  input  logic [rss_pkg::CellBits-1:0] wdata_i,
  input  logic                         re_i,
  input  logic [rss_pkg::AddrBits-1:0] raddr_i,
  output logic [rss_pkg::CellBits-1:0] rdata_o
);
  import rss_pkg::*;

  logic [CellBits-1:0] mem [StoreDepth];
  logic [CellBits-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/rotated_sprite_sampler.sv =====
// Rotated sprite sampler: image store plus inverse-rotation sampling pipeline.
//
// Channels: config writes (cfg_valid_i/cfg_index_i/cfg_data_i, always ready),
// input transactions (in_valid_i/in_ready_o/in_data_i) and results
// (out_valid_o/out_ready_i/out_data_o). A write transaction (opcode 0) stores
// one image cell and gives no result; a sample transaction (opcode 1) gives
// one result. Throughput is one transaction per cycle unless the output or a
// config write holds the input: a three-stage mapper (offset, four parallel
// 32x16 products, rounding) feeds the image memory (one write and one read
// port), whose registered read data goes to the output register.
// Cell writes land in the memory stage, in order with the reads, so a sample
// always sees every earlier write.
// After reset or a config write, in_ready_o stays low while the rotated
// bounding box is recomputed in its own three-stage pipeline.
// Reset clears the registers to sine 0, cosine 1.0, all else zero; the image
// memory is not cleared and a cell must be written before it is sampled.
// When out_ready_i is low with a result waiting, the whole pipeline holds and
// in_ready_o drops; nothing is lost.
module rotated_sprite_sampler (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [2:0]    cfg_index_i,
  input  logic [15:0]   cfg_data_i,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  rss_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output rss_pkg::out_t out_data_o
);
  import rss_pkg::*;

  cfg_t cfg;
  box_t box;
  map_t map;
  logic busy, adv, accept;

  logic [CellBits-1:0] rdata;
  logic                rd_valid_q, rd_hit_q;
  logic [ColBits-1:0]  rd_col_q;
  logic [RowBits-1:0]  rd_row_q;

  logic out_valid_q;
  out_t out_q, out_d;

  assign adv         = !out_valid_q || out_ready_i;
  assign in_ready_o  = adv && !busy;
  assign accept      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  rss_geometry u_geometry (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg),
    .box_o       (box),
    .busy_o      (busy)
  );

  rss_mapper u_mapper (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (adv),
    .accept_i  (accept),
    .in_data_i (in_data_i),
    .cfg_i     (cfg),
    .box_i     (box),
    .map_o     (map)
  );

  rss_store u_store (
    .clk_i   (clk_i),
    .we_i    (adv && map.valid && (map.opcode == OP_WRITE)),
    .waddr_i ({map.cell_row, map.cell_col}),
    .wdata_i (map.cell_data),
    .re_i    (adv),
    .raddr_i ({map.src_row, map.src_col}),
    .rdata_o (rdata)
  );

  // Tags that travel alongside the memory read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_valid_q <= 1'b0;
    end else if (adv) begin
      rd_valid_q <= map.valid && (map.opcode == OP_SAMPLE);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rd_hit_q <= map.hit;
      rd_col_q <= map.src_col;
      rd_row_q <= map.src_row;
    end
  end

  always_comb begin
    out_d            = '0;
    out_d.out_color  = cfg.transparent;
    out_d.write_mode = WM_NONE;
    if (rd_hit_q) begin
      out_d.hit           = 1'b1;
      out_d.out_char      = rdata[7:0];
      out_d.out_color     = rdata[23:8];
      out_d.source_column = 6'(rd_col_q);
      out_d.source_row    = 6'(rd_row_q);
      if (rdata[23:8] != cfg.transparent) begin
        out_d.write_mode = WM_FULL;
      end else if (rdata[7:0] != 8'd0) begin
        out_d.write_mode = WM_CHAR;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= rd_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the rotated sprite sampler.
`timescale 1ns / 100ps

module tb;
  import rss_pkg::*;

  localparam logic [2:0] RegSpare = 3'd7;  // no register behind this index

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic        cfg_valid = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready_o;
  in_t         in_data = '0;
  logic        out_valid_o;
  logic        out_ready = 1'b0;
  out_t        out_data_o;

  rotated_sprite_sampler u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_data_o  (out_data_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Shadow copy of the block's registers and image memory
  cfg_t        cur_cfg;
  logic [23:0] image_copy [StoreDepth];
  bit          cell_written [StoreDepth];

  in_t  pending_ops [$];
  out_t expected_pixels [$];

  int n_errors = 0;
  int n_checked = 0;
  int n_hits = 0;
  int n_full = 0;
  int n_char = 0;
  int n_none = 0;
  int n_cell_writes = 0;
  int n_settings = 0;
  int n_rx_holds = 0;
  int n_tx_pauses = 0;

  bit   hold_tx = 1'b0;
  logic hold_rx_req = 1'b0;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    n_errors++;
    if (n_errors <= 40)
      $display("tb: mismatch on %s: got %0d, want %0d (t=%0t)", what, got, want, $time);
  endtask

  function automatic void span3(input longint a, b, c, output longint lo, hi);
    lo = 0;
    hi = 0;
    if (a < lo) lo = a;
    if (b < lo) lo = b;
    if (c < lo) lo = c;
    if (a > hi) hi = a;
    if (b > hi) hi = b;
    if (c > hi) hi = c;
  endfunction

  // Rotated bounding box of the current setting, offsets in Q.14
  function automatic void box_of(output longint minx, miny, bw, bh, left, top);
    longint w, h, s, c, maxx, maxy;
    w = cur_cfg.width;
    h = cur_cfg.height;
    s = $signed(cur_cfg.sine);
    c = $signed(cur_cfg.cosine);
    span3(-h * s, w * c - h * s, w * c, minx, maxx);
    span3(h * c, h * c + w * s, w * s, miny, maxy);
    bw = (maxx - minx + longint'(HalfQ14)) >>> 14;
    bh = (maxy - miny + longint'(HalfQ14)) >>> 14;
    left = longint'($signed(cur_cfg.pos_x)) + (w >>> 1) - (bw >>> 1);
    top  = longint'($signed(cur_cfg.pos_y)) + (h >>> 1) - (bh >>> 1);
  endfunction

  // Screen point back into the image, round to nearest
  function automatic void inverse_map(input longint scr_x, scr_y, output bit hit,
                                      output int col, row);
    longint minx, miny, bw, bh, left, top, s, c, px, py, ux, uy;
    box_of(minx, miny, bw, bh, left, top);
    s = $signed(cur_cfg.sine);
    c = $signed(cur_cfg.cosine);
    px = (scr_x - left) * 16384 + minx;
    py = (scr_y - top) * 16384 + miny;
    ux = (px * c + py * s + longint'(HalfQ28)) >>> 28;
    uy = (py * c - px * s + longint'(HalfQ28)) >>> 28;
    hit = ux >= 0 && ux < longint'(cur_cfg.width) && uy >= 0 &&
          uy < longint'(cur_cfg.height);
    col = hit ? int'(ux) : 0;
    row = hit ? int'(uy) : 0;
  endfunction

  // Called once per accepted input transaction
  task automatic predict_op(input in_t op);
    bit          hit;
    int          col, row;
    logic [23:0] word;
    out_t        want;
    if (op.opcode == OP_WRITE) begin
      image_copy[{op.cell_row, op.cell_column}] = {op.cell_color, op.cell_char};
      n_cell_writes++;
    end else begin
      inverse_map(longint'($signed(op.screen_x)), longint'($signed(op.screen_y)),
                  hit, col, row);
      want = '0;
      want.out_color = cur_cfg.transparent;
      want.write_mode = WM_NONE;
      if (hit) begin
        word = image_copy[row * MaxWidth + col];
        want.hit = 1'b1;
        want.out_char = word[7:0];
        want.out_color = word[23:8];
        if (word[23:8] != cur_cfg.transparent) want.write_mode = WM_FULL;
        else if (word[7:0] != 8'd0) want.write_mode = WM_CHAR;
        want.source_column = col[5:0];
        want.source_row = row[5:0];
      end
      expected_pixels.push_back(want);
    end
  endtask

  // Sender: bursts of random length separated by random gaps
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_data <= '0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (in_valid && in_ready_o) predict_op(in_data);
      if (!in_valid || in_ready_o) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (hold_tx || pending_ops.size() == 0) begin
          in_valid <= 1'b0;
        end else begin
          in_data <= pending_ops.pop_front();
          in_valid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 24);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left <= burst_left - 1;
          end
        end
      end
    end
  end

  // Receiver: stall pattern re-drawn each time rx_cnt[5:0] wraps to zero; long hold on request
  logic [7:0] rx_cnt = '0;
  int         rx_mode = 0;
  int         hold_cnt = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
      rx_cnt <= '0;
      rx_mode <= 0;
      hold_cnt <= 0;
    end else begin
      rx_cnt <= rx_cnt + 8'd1;
      if (rx_cnt[5:0] == 6'd0) rx_mode <= $urandom_range(0, 3);
      if (hold_rx_req) hold_cnt <= 400;
      else if (hold_cnt != 0) hold_cnt <= hold_cnt - 1;
      if (hold_rx_req || hold_cnt != 0) out_ready <= 1'b0;
      else begin
        case (rx_mode)
          1: out_ready <= $urandom_range(0, 1);
          2: out_ready <= (rx_cnt[1:0] == 2'd3);
          default: out_ready <= 1'b1;
        endcase
      end
    end
  end

  // Result checker
  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && out_valid_o && out_ready) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch("result with nothing pending", 1, 0);
      end else begin
        want = expected_pixels.pop_front();
        n_checked++;
        if (want.hit) n_hits++;
        if (want.write_mode == WM_FULL) n_full++;
        else if (want.write_mode == WM_CHAR) n_char++;
        else n_none++;
        if (out_data_o.hit !== want.hit)
          report_mismatch("hit", out_data_o.hit, want.hit);
        if (out_data_o.out_char !== want.out_char)
          report_mismatch("out_char", out_data_o.out_char, want.out_char);
        if (out_data_o.out_color !== want.out_color)
          report_mismatch("out_color", out_data_o.out_color, want.out_color);
        if (out_data_o.write_mode !== want.write_mode)
          report_mismatch("write_mode", out_data_o.write_mode, want.write_mode);
        if (out_data_o.source_column !== want.source_column)
          report_mismatch("source_column", out_data_o.source_column, want.source_column);
        if (out_data_o.source_row !== want.source_row)
          report_mismatch("source_row", out_data_o.source_row, want.source_row);
      end
    end
  end

  task automatic cfg_write(input logic [2:0] idx, input logic [15:0] data);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid <= 1'b0;
    case (cfg_reg_e'(idx))
      REG_SINE:        cur_cfg.sine = data;
      REG_COSINE:      cur_cfg.cosine = data;
      REG_WIDTH:       cur_cfg.width = (data[6:0] > MaxWidth) ? 7'(MaxWidth) : data[6:0];
      REG_HEIGHT:      cur_cfg.height = (data[6:0] > MaxHeight) ? 7'(MaxHeight) : data[6:0];
      REG_POS_X:       cur_cfg.pos_x = data[CoordBits-1:0];
      REG_POS_Y:       cur_cfg.pos_y = data[CoordBits-1:0];
      REG_TRANSPARENT: cur_cfg.transparent = data;
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [15:0] s, c, w, h, px, py, tc);
    cfg_write(REG_SINE, s);
    cfg_write(REG_COSINE, c);
    cfg_write(REG_WIDTH, w);
    cfg_write(REG_HEIGHT, h);
    cfg_write(REG_POS_X, px);
    cfg_write(REG_POS_Y, py);
    cfg_write(REG_TRANSPARENT, tc);
    n_settings++;
    @(negedge clk_i);
  endtask

  // Block drained; extra cycles let trailing cell writes land
  task automatic wait_idle();
    int guard = 0;
    @(negedge clk_i);
    while ((pending_ops.size() != 0 || in_valid || expected_pixels.size() != 0) &&
           guard < 200000) begin
      @(negedge clk_i);
      guard++;
    end
    repeat (12) @(negedge clk_i);
  endtask

  function automatic in_t noise_op();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return r[$bits(in_t)-1:0];
  endfunction

  function automatic logic [7:0] pick_char();
    case ($urandom_range(0, 3))
      0: return 8'd0;
      1: return 8'hFF;
      default: return 8'($urandom());
    endcase
  endfunction

  function automatic logic [15:0] pick_color();
    case ($urandom_range(0, 5))
      0, 1: return cur_cfg.transparent;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic push_write(input int col, row, input logic [7:0] ch,
                            input logic [15:0] color);
    in_t op;
    op = noise_op();
    op.opcode = OP_WRITE;
    op.cell_column = 6'(col);
    op.cell_row = 6'(row);
    op.cell_char = ch;
    op.cell_color = color;
    cell_written[row * MaxWidth + col] = 1'b1;
    pending_ops.push_back(op);
  endtask

  // A probe that would land on a never-written cell gets that cell written first
  task automatic push_probe(input longint x, y);
    in_t op;
    bit  hit;
    int  col, row;
    if (x < -2048) x = -2048;
    if (x > 2047) x = 2047;
    if (y < -2048) y = -2048;
    if (y > 2047) y = 2047;
    inverse_map(x, y, hit, col, row);
    if (hit && !cell_written[row * MaxWidth + col])
      push_write(col, row, pick_char(), pick_color());
    op = noise_op();
    op.opcode = OP_SAMPLE;
    op.screen_x = x[CoordBits-1:0];
    op.screen_y = y[CoordBits-1:0];
    pending_ops.push_back(op);
  endtask

  task automatic random_items(input int n_ops);
    longint minx, miny, bw, bh, left, top;
    int     pick, col, row;
    box_of(minx, miny, bw, bh, left, top);
    for (int i = 0; i < n_ops; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        if (cur_cfg.width != 0 && cur_cfg.height != 0 && $urandom_range(0, 3) != 0) begin
          col = $urandom_range(0, cur_cfg.width - 1);
          row = $urandom_range(0, cur_cfg.height - 1);
        end else begin
          col = $urandom_range(0, 63);
          row = $urandom_range(0, 63);
        end
        push_write(col, row, pick_char(), pick_color());
      end else if (pick < 35) begin
        push_probe(longint'($urandom_range(0, 4095)) - 2048,
                   longint'($urandom_range(0, 4095)) - 2048);
      end else begin
        push_probe(left + longint'($urandom_range(0, int'(bw) + 8)) - 4,
                   top + longint'($urandom_range(0, int'(bh) + 8)) - 4);
      end
    end
  endtask

  task automatic random_phase(input int n_ops, input bit rx_hold, input bit tx_pause);
    int          s, c, w, h, px, py;
    real         ang;
    logic [15:0] wd, hd, pxd, pyd, tc;
    if ($urandom_range(0, 4) == 0) begin
      s = int'($urandom_range(0, 32768)) - 16384;
      c = int'($urandom_range(0, 32768)) - 16384;
    end else begin
      ang = $urandom_range(0, 359) * 3.14159265358979 / 180.0;
      s = int'(16384.0 * $sin(ang));
      c = int'(16384.0 * $cos(ang));
    end
    case ($urandom_range(0, 9))
      0: w = 0;
      1: w = $urandom_range(65, 127);
      2, 3, 4: w = $urandom_range(1, 8);
      default: w = $urandom_range(1, 64);
    endcase
    case ($urandom_range(0, 9))
      0: h = 0;
      1: h = $urandom_range(65, 127);
      2, 3, 4: h = $urandom_range(1, 8);
      default: h = $urandom_range(1, 64);
    endcase
    wd = 16'(w);
    hd = 16'(h);
    // upper bits beyond the register width must be dropped
    if ($urandom_range(0, 3) == 0) wd[15:7] = 9'($urandom());
    if ($urandom_range(0, 3) == 0) hd[15:7] = 9'($urandom());
    px = ($urandom_range(0, 5) == 0) ? int'($urandom_range(0, 4095)) - 2048
                                      : int'($urandom_range(0, 600)) - 300;
    py = ($urandom_range(0, 5) == 0) ? int'($urandom_range(0, 4095)) - 2048
                                      : int'($urandom_range(0, 600)) - 300;
    pxd = 16'(px);
    pyd = 16'(py);
    if ($urandom_range(0, 3) == 0) pxd[15:12] = 4'($urandom());
    if ($urandom_range(0, 3) == 0) pyd[15:12] = 4'($urandom());
    case ($urandom_range(0, 3))
      0: tc = 16'h0000;
      1: tc = 16'hFFFF;
      default: tc = 16'($urandom());
    endcase
    wait_idle();
    set_config(16'(s), 16'(c), wd, hd, pxd, pyd, tc);
    random_items(n_ops);
    if (rx_hold) begin
      hold_rx_req <= 1'b1;
      @(negedge clk_i);
      hold_rx_req <= 1'b0;
      n_rx_holds++;
    end
    if (tx_pause) begin
      while (pending_ops.size() > n_ops / 2) @(negedge clk_i);
      hold_tx = 1'b1;
      while (in_valid || expected_pixels.size() != 0) @(negedge clk_i);
      repeat (5) @(negedge clk_i);
      hold_tx = 1'b0;
      n_tx_pauses++;
    end
  endtask

  initial begin
    cur_cfg = '0;
    cur_cfg.cosine = 16'sd16384;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait_idle();

    // Reset setting has an empty image: everything misses
    push_probe(-2048, -2048);
    push_probe(2047, 2047);
    push_probe(0, 0);
    push_write(0, 0, 8'h00, 16'h0000);
    push_write(63, 63, 8'hFF, 16'h0000);
    push_write(63, 0, 8'h00, 16'hFFFF);
    push_write(0, 63, 8'hA5, 16'h5A5A);

    // Identity mapping over the full image: corners show every write mode
    wait_idle();
    set_config(16'd0, 16'd16384, 16'd64, 16'd64, 16'd0, 16'd0, 16'h0000);
    push_probe(0, 0);
    push_probe(63, 63);
    push_probe(63, 0);
    push_probe(0, 63);
    push_probe(64, 0);
    push_probe(-1, 5);
    push_probe(5, 64);
    push_probe(10, 20);

    // Quarter turn, oversized image saturating, positions at the coordinate limits
    wait_idle();
    set_config(16'd16384, 16'd0, 16'h007F, 16'h1F64, 16'h07FF, 16'hF800, 16'hFFFF);
    cfg_write(RegSpare, 16'hFFFF);
    @(negedge clk_i);
    random_items(30);

    // Sine and cosine of -1.0, single-cell image
    wait_idle();
    set_config(16'hC000, 16'hC000, 16'd1, 16'd1, 16'hA800, 16'h07FF, 16'($urandom()));
    random_items(20);

    for (int p = 0; p < 12; p++) random_phase(70, p == 2, p == 5);

    wait_idle();
    repeat (20) @(negedge clk_i);
    if (expected_pixels.size() != 0)
      report_mismatch("results never delivered", 0, expected_pixels.size());
    $display("tb: %0d probes checked, %0d hits (full %0d, char only %0d, none %0d)",
             n_checked, n_hits, n_full, n_char, n_none);
    $display("tb: %0d cell writes over %0d register settings, %0d output holds, %0d input pauses",
             n_cell_writes, n_settings, n_rx_holds, n_tx_pauses);
    if (n_errors == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("tb: FAIL");
    $finish;
  end

endmodule

// ===== files.f =====
sv/rss_pkg.sv
sv/rss_geometry.sv
sv/rss_mapper.sv
sv/rss_store.sv
sv/rotated_sprite_sampler.sv
tb/tb.sv
